FILE: rtl/brs_pkg.sv
// Shared widths, codes and constants of the bilinear resampler.
`default_nettype none

package brs_pkg;

  // Store geometry
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int DIM_W      = 9;
  localparam int NUM_BANKS  = 4;
  localparam int BANK_SEL_W = 2;
  localparam int BANK_AW    = COL_W + ROW_W - 2;
  localparam int BANK_DEPTH = (MAX_WIDTH * MAX_HEIGHT) / NUM_BANKS;

  // Arithmetic widths
  localparam int FRAC_BITS = 16;
  localparam int STEP_W    = 20;
  localparam int PIX_W     = 16;
  localparam int POS_W     = COL_W + STEP_W;
  localparam int INT_W     = POS_W - FRAC_BITS;
  localparam int CMP_W     = INT_W + 1;
  localparam int WT_W      = 2 * FRAC_BITS + 1;
  localparam int TERM_W    = PIX_W + WT_W + 1;
  localparam int SUM_W     = TERM_W + 2;
  localparam int VF_W      = SUM_W - FRAC_BITS;
  localparam int SCF_W     = 2 * STEP_W - FRAC_BITS;
  localparam int PROD_W    = VF_W + SCF_W + 1;
  localparam int VAL_W     = 48;
  localparam int WIDE_W    = 64;

  localparam logic [FRAC_BITS:0] FRAC_ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;
  localparam logic signed [WIDE_W-1:0] VALUE_MAX = (64'sd1 <<< (VAL_W - 1)) - 64'sd1;
  localparam logic signed [WIDE_W-1:0] VALUE_MIN = -VALUE_MAX - 64'sd1;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = STEP_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 2'd0,
    REG_SRC_HEIGHT = 2'd1,
    REG_STEP_X     = 2'd2,
    REG_STEP_Y     = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    FUNC_LOAD     = 1'b0,
    FUNC_RESAMPLE = 1'b1
  } func_t;

  // Bank codes: {row parity, column parity}
  localparam logic [BANK_SEL_W-1:0] BANK_EE = 2'b00;
  localparam logic [BANK_SEL_W-1:0] BANK_EO = 2'b01;
  localparam logic [BANK_SEL_W-1:0] BANK_OE = 2'b10;
  localparam logic [BANK_SEL_W-1:0] BANK_OO = 2'b11;

endpackage

`default_nettype wire

FILE: rtl/brs_in_if.sv
// Request channel: load and resample items.
`default_nettype none

interface brs_in_if;
  import brs_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    func;
  logic [COL_W-1:0]        src_col;
  logic [ROW_W-1:0]        src_row;
  logic signed [PIX_W-1:0] sample;
  logic [COL_W-1:0]        out_col;
  logic [ROW_W-1:0]        out_row;

  modport source (output valid, func, src_col, src_row, sample, out_col, out_row,
                  input ready);
  modport sink   (input valid, func, src_col, src_row, sample, out_col, out_row,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/brs_out_if.sv
// Result channel: one resampled pixel per resample item.
`default_nettype none

interface brs_out_if;
  import brs_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [COL_W-1:0]        res_col;
  logic [ROW_W-1:0]        res_row;
  logic signed [VAL_W-1:0] value;
  logic                    edge_copy;
  logic                    saturated;

  modport source (output valid, res_col, res_row, value, edge_copy, saturated,
                  input ready);
  modport sink   (input valid, res_col, res_row, value, edge_copy, saturated,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/brs_cfg_if.sv
// Register write channel.
`default_nettype none

interface brs_cfg_if;
  import brs_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/bilinear_image_resampler_core.sv
// Bilinear resampler core: source store, six-stage datapath and output register.
//
// Each item passes seven registers (input/multiply, position, store read,
// weighting, sum, scale, output), and one item is taken every cycle while the
// output is drained. The source store is four parity banks of 128 x 128
// pixels, each with one write and one registered read port; the four
// neighbours of a position always sit in different banks, which sets the rate
// at one item per cycle. Loads write the store in the same stage that
// resamples read it, so a pixel loaded by any earlier item is seen. The store
// has no reset and needs no clearing pass; only pixels already loaded may be
// sampled. Registers must be written only while no item is in flight; the
// block does not enforce this, and cfg is always ready.
`default_nettype none

module bilinear_image_resampler_core (
  input  wire logic clk,
  input  wire logic rst,
  brs_in_if.sink    req,
  brs_out_if.source res,
  brs_cfg_if.sink   cfg
);
  import brs_pkg::*;

  // Configuration
  logic [DIM_W-1:0]  src_width;
  logic [DIM_W-1:0]  src_height;
  logic [STEP_W-1:0] step_x;
  logic [STEP_W-1:0] step_y;
  logic [SCF_W-1:0]  scf;
  logic [DIM_W-1:0]  w_dim;
  logic [DIM_W-1:0]  h_dim;

  // Stage enables
  logic en_a, en_b, en_c, en_d, en_e, en_f, en_o;

  // Stage A
  logic                    a_v;
  logic                    a_func;
  logic [COL_W-1:0]        a_src_col;
  logic [ROW_W-1:0]        a_src_row;
  logic signed [PIX_W-1:0] a_sample;
  logic [COL_W-1:0]        a_ocol;
  logic [ROW_W-1:0]        a_orow;
  logic [POS_W-1:0]        a_px;
  logic [POS_W-1:0]        a_py;
  logic [INT_W-1:0]        a_j;
  logic [INT_W-1:0]        a_k;
  logic                    a_inside;
  logic [COL_W-1:0]        a_bc;
  logic [ROW_W-1:0]        a_br;

  // Stage B
  logic                    b_v;
  logic                    b_func;
  logic [COL_W-1:0]        b_src_col;
  logic [ROW_W-1:0]        b_src_row;
  logic signed [PIX_W-1:0] b_sample;
  logic [COL_W-1:0]        b_ocol;
  logic [ROW_W-1:0]        b_orow;
  logic [FRAC_BITS-1:0]    b_t;
  logic [FRAC_BITS-1:0]    b_u;
  logic [COL_W-1:0]        b_bc;
  logic [ROW_W-1:0]        b_br;
  logic                    b_inside;
  logic [FRAC_BITS:0]      b_omt;
  logic [FRAC_BITS:0]      b_omu;
  logic [COL_W:0]          b_bc_up;
  logic [ROW_W:0]          b_br_up;
  logic [BANK_AW-1:0]      rd_addr [NUM_BANKS];
  logic [BANK_AW-1:0]      wr_addr;
  logic [BANK_SEL_W-1:0]   wr_bank;
  logic                    we;

  // Stage C
  logic                    c_v;
  logic                    c_func;
  logic [COL_W-1:0]        c_ocol;
  logic [ROW_W-1:0]        c_orow;
  logic                    c_inside;
  logic                    c_bc0;
  logic                    c_br0;
  logic [WT_W-1:0]         c_wt00;
  logic [WT_W-1:0]         c_wt01;
  logic [WT_W-1:0]         c_wt10;
  logic [WT_W-1:0]         c_wt11;
  logic [PIX_W-1:0]        c_rd [NUM_BANKS];
  logic signed [PIX_W-1:0] c_p00;
  logic signed [PIX_W-1:0] c_p01;
  logic signed [PIX_W-1:0] c_p10;
  logic signed [PIX_W-1:0] c_p11;

  // Stage D
  logic                     d_v;
  logic                     d_func;
  logic [COL_W-1:0]         d_ocol;
  logic [ROW_W-1:0]         d_orow;
  logic                     d_inside;
  logic signed [PIX_W-1:0]  d_edge_pix;
  logic signed [TERM_W-1:0] d_t00;
  logic signed [TERM_W-1:0] d_t01;
  logic signed [TERM_W-1:0] d_t10;
  logic signed [TERM_W-1:0] d_t11;
  logic signed [SUM_W-1:0]  d_sum;

  // Stage E
  logic                     e_v;
  logic                     e_func;
  logic [COL_W-1:0]         e_ocol;
  logic [ROW_W-1:0]         e_orow;
  logic                     e_inside;
  logic signed [PIX_W-1:0]  e_edge_pix;
  logic signed [VF_W-1:0]   e_vf;

  // Stage F
  logic                          f_v;
  logic                          f_func;
  logic [COL_W-1:0]              f_ocol;
  logic [ROW_W-1:0]              f_orow;
  logic                          f_inside;
  logic signed [PIX_W-1:0]       f_edge_pix;
  logic signed [PROD_W-1:0]      f_prod;
  logic signed [PROD_W-FRAC_BITS-1:0] f_val;
  logic signed [WIDE_W-1:0]      f_wide;
  logic signed [WIDE_W-1:0]      f_edge_wide;
  logic                          f_sat_hi;
  logic                          f_sat_lo;
  logic [VAL_W-1:0]              f_value;

  // Output register
  logic                    o_v;
  logic [COL_W-1:0]        o_ocol;
  logic [ROW_W-1:0]        o_orow;
  logic [VAL_W-1:0]        o_value;
  logic                    o_edge;
  logic                    o_sat;

  // ---------------------------------------------------------------- config
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width  <= DIM_W'(MAX_WIDTH);
      src_height <= DIM_W'(MAX_HEIGHT);
      step_x     <= STEP_W'(FRAC_ONE);
      step_y     <= STEP_W'(FRAC_ONE);
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_SRC_WIDTH:  src_width  <= cfg.data[DIM_W-1:0];
        REG_SRC_HEIGHT: src_height <= cfg.data[DIM_W-1:0];
        REG_STEP_X:     step_x     <= cfg.data[STEP_W-1:0];
        REG_STEP_Y:     step_y     <= cfg.data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Area scale, static while items are in flight
  always_ff @(posedge clk) begin
    scf <= SCF_W'(((2 * STEP_W)'(step_x) * (2 * STEP_W)'(step_y)) >> FRAC_BITS);
  end

  always_comb begin
    if (src_width == '0) begin
      w_dim = DIM_W'(1);
    end else if (src_width > DIM_W'(MAX_WIDTH)) begin
      w_dim = DIM_W'(MAX_WIDTH);
    end else begin
      w_dim = src_width;
    end
    if (src_height == '0) begin
      h_dim = DIM_W'(1);
    end else if (src_height > DIM_W'(MAX_HEIGHT)) begin
      h_dim = DIM_W'(MAX_HEIGHT);
    end else begin
      h_dim = src_height;
    end
  end

  // ---------------------------------------------------------------- flow
  // A stage advances when it is empty or the stage after it advances.
  assign en_o = !o_v || res.ready;
  assign en_f = !f_v || en_o;
  assign en_e = !e_v || en_f;
  assign en_d = !d_v || en_e;
  assign en_c = !c_v || en_d;
  assign en_b = !b_v || en_c;
  assign en_a = !a_v || en_b;
  assign req.ready = en_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
      c_v <= 1'b0;
      d_v <= 1'b0;
      e_v <= 1'b0;
      f_v <= 1'b0;
      o_v <= 1'b0;
    end else begin
      if (en_a) a_v <= req.valid;
      if (en_b) b_v <= a_v;
      if (en_c) c_v <= b_v;
      if (en_d) d_v <= c_v;
      if (en_e) e_v <= d_v;
      if (en_f) f_v <= e_v;
      // loads end here without a result
      if (en_o) o_v <= f_v && (f_func == FUNC_RESAMPLE);
    end
  end

  // ---------------------------------------------------------------- stage A
  always_ff @(posedge clk) begin
    if (en_a) begin
      a_func    <= req.func;
      a_src_col <= req.src_col;
      a_src_row <= req.src_row;
      a_sample  <= req.sample;
      a_ocol    <= req.out_col;
      a_orow    <= req.out_row;
      a_px      <= POS_W'(req.out_col) * POS_W'(step_x);
      a_py      <= POS_W'(req.out_row) * POS_W'(step_y);
    end
  end

  always_comb begin
    a_j = a_px[POS_W-1:FRAC_BITS];
    a_k = a_py[POS_W-1:FRAC_BITS];
    a_inside = ((CMP_W'(a_j) + CMP_W'(1)) < CMP_W'(w_dim)) &&
               ((CMP_W'(a_k) + CMP_W'(1)) < CMP_W'(h_dim));
    // clamp the base pixel to the last column and row for the edge copy
    a_bc = (CMP_W'(a_j) < CMP_W'(w_dim)) ? a_j[COL_W-1:0] : COL_W'(w_dim - DIM_W'(1));
    a_br = (CMP_W'(a_k) < CMP_W'(h_dim)) ? a_k[ROW_W-1:0] : ROW_W'(h_dim - DIM_W'(1));
  end

  // ---------------------------------------------------------------- stage B
  always_ff @(posedge clk) begin
    if (en_b) begin
      b_func    <= a_func;
      b_src_col <= a_src_col;
      b_src_row <= a_src_row;
      b_sample  <= a_sample;
      b_ocol    <= a_ocol;
      b_orow    <= a_orow;
      b_t       <= a_px[FRAC_BITS-1:0];
      b_u       <= a_py[FRAC_BITS-1:0];
      b_bc      <= a_bc;
      b_br      <= a_br;
      b_inside  <= a_inside;
    end
  end

  always_comb begin
    logic [BANK_SEL_W-1:0] sel;
    logic [COL_W-2:0]      col_a;
    logic [ROW_W-2:0]      row_a;
    sel   = '0;
    col_a = '0;
    row_a = '0;
    b_omt   = FRAC_ONE - (FRAC_BITS + 1)'(b_t);
    b_omu   = FRAC_ONE - (FRAC_BITS + 1)'(b_u);
    b_bc_up = (COL_W + 1)'(b_bc) + (COL_W + 1)'(1);
    b_br_up = (ROW_W + 1)'(b_br) + (ROW_W + 1)'(1);
    // even banks hold the neighbour at base or base + 1, whichever is even
    for (int i = 0; i < NUM_BANKS; i++) begin
      sel   = BANK_SEL_W'(i);
      col_a = sel[0] ? b_bc[COL_W-1:1] : b_bc_up[COL_W-1:1];
      row_a = sel[1] ? b_br[ROW_W-1:1] : b_br_up[ROW_W-1:1];
      rd_addr[i] = {row_a, col_a};
    end
    wr_bank = {b_src_row[0], b_src_col[0]};
    wr_addr = {b_src_row[ROW_W-1:1], b_src_col[COL_W-1:1]};
    we      = b_v && (b_func == FUNC_LOAD);
  end

  // ---------------------------------------------------------------- stage C: store
  for (genvar g = 0; g < NUM_BANKS; g++) begin : g_bank
    logic [PIX_W-1:0] store [BANK_DEPTH];

    always_ff @(posedge clk) begin
      if (en_c) begin
        if (we && (wr_bank == BANK_SEL_W'(g))) begin
          store[wr_addr] <= b_sample;
        end
        c_rd[g] <= store[rd_addr[g]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_c) begin
      c_func   <= b_func;
      c_ocol   <= b_ocol;
      c_orow   <= b_orow;
      c_inside <= b_inside;
      c_bc0    <= b_bc[0];
      c_br0    <= b_br[0];
      c_wt00   <= WT_W'(b_omt) * WT_W'(b_omu);
      c_wt01   <= WT_W'(b_t) * WT_W'(b_omu);
      c_wt10   <= WT_W'(b_omt) * WT_W'(b_u);
      c_wt11   <= WT_W'(b_t) * WT_W'(b_u);
    end
  end

  // Route banks to neighbours by base parity
  always_comb begin
    c_p00 = c_br0 ? (c_bc0 ? c_rd[BANK_OO] : c_rd[BANK_OE])
                  : (c_bc0 ? c_rd[BANK_EO] : c_rd[BANK_EE]);
    c_p01 = c_br0 ? (c_bc0 ? c_rd[BANK_OE] : c_rd[BANK_OO])
                  : (c_bc0 ? c_rd[BANK_EE] : c_rd[BANK_EO]);
    c_p10 = c_br0 ? (c_bc0 ? c_rd[BANK_EO] : c_rd[BANK_EE])
                  : (c_bc0 ? c_rd[BANK_OO] : c_rd[BANK_OE]);
    c_p11 = c_br0 ? (c_bc0 ? c_rd[BANK_EE] : c_rd[BANK_EO])
                  : (c_bc0 ? c_rd[BANK_OE] : c_rd[BANK_OO]);
  end

  // ---------------------------------------------------------------- stage D
  always_ff @(posedge clk) begin
    if (en_d) begin
      d_func     <= c_func;
      d_ocol     <= c_ocol;
      d_orow     <= c_orow;
      d_inside   <= c_inside;
      d_edge_pix <= c_p00;
      d_t00      <= TERM_W'(c_p00) * TERM_W'($signed({1'b0, c_wt00}));
      d_t01      <= TERM_W'(c_p01) * TERM_W'($signed({1'b0, c_wt01}));
      d_t10      <= TERM_W'(c_p10) * TERM_W'($signed({1'b0, c_wt10}));
      d_t11      <= TERM_W'(c_p11) * TERM_W'($signed({1'b0, c_wt11}));
    end
  end

  assign d_sum = SUM_W'(d_t00) + SUM_W'(d_t01) + SUM_W'(d_t10) + SUM_W'(d_t11);

  // ---------------------------------------------------------------- stage E
  always_ff @(posedge clk) begin
    if (en_e) begin
      e_func     <= d_func;
      e_ocol     <= d_ocol;
      e_orow     <= d_orow;
      e_inside   <= d_inside;
      e_edge_pix <= d_edge_pix;
      // floor to FRAC_BITS fraction bits
      e_vf       <= d_sum[SUM_W-1:FRAC_BITS];
    end
  end

  // ---------------------------------------------------------------- stage F
  always_ff @(posedge clk) begin
    if (en_f) begin
      f_func     <= e_func;
      f_ocol     <= e_ocol;
      f_orow     <= e_orow;
      f_inside   <= e_inside;
      f_edge_pix <= e_edge_pix;
      f_prod     <= PROD_W'(e_vf) * PROD_W'($signed({1'b0, scf}));
    end
  end

  always_comb begin
    f_val       = f_prod[PROD_W-1:FRAC_BITS];
    f_wide      = WIDE_W'(f_val);
    f_edge_wide = WIDE_W'(f_edge_pix) <<< FRAC_BITS;
    f_sat_hi    = f_inside && (f_wide > VALUE_MAX);
    f_sat_lo    = f_inside && (f_wide < VALUE_MIN);
    if (!f_inside) begin
      f_value = f_edge_wide[VAL_W-1:0];
    end else if (f_sat_hi) begin
      f_value = VALUE_MAX[VAL_W-1:0];
    end else if (f_sat_lo) begin
      f_value = VALUE_MIN[VAL_W-1:0];
    end else begin
      f_value = f_wide[VAL_W-1:0];
    end
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (en_o) begin
      o_ocol  <= f_ocol;
      o_orow  <= f_orow;
      o_value <= f_value;
      o_edge  <= !f_inside;
      o_sat   <= f_sat_hi || f_sat_lo;
    end
  end

  assign res.valid     = o_v;
  assign res.res_col   = o_ocol;
  assign res.res_row   = o_orow;
  assign res.value     = o_value;
  assign res.edge_copy = o_edge;
  assign res.saturated = o_sat;

  // ---------------------------------------------------------------- checks
  a_no_ready_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> (a_v && b_v && c_v && d_v && e_v && f_v && o_v))
    else $error("input blocked while the pipeline has a bubble");

  a_resample_reaches_output: assert property (@(posedge clk) disable iff (rst)
    (f_v && (f_func == FUNC_RESAMPLE) && en_o) |=> res.valid)
    else $error("resample item lost at the output register");

  a_load_gives_no_result: assert property (@(posedge clk) disable iff (rst)
    (f_v && (f_func == FUNC_LOAD) && en_o) |=> !res.valid)
    else $error("load item produced a result");

  a_edge_copy_whole: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.edge_copy) |->
      (res.value[FRAC_BITS-1:0] == '0 && !res.saturated))
    else $error("edge copy carries a fraction or a clip");

  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.saturated) |->
      (res.value == VALUE_MAX[VAL_W-1:0] || res.value == VALUE_MIN[VAL_W-1:0]))
    else $error("clipped value is not at a range limit");

endmodule

`default_nettype wire

FILE: tb/sv/bilinear_image_resampler_core_checker.sv
// Resampler checker: mirrors loads and register writes, predicts each output pixel, compares.
module bilinear_image_resampler_core_checker (
  input  wire logic clk,
  input  wire logic rst,
  brs_in_if         req,
  brs_out_if        res,
  brs_cfg_if        cfg,
  input  wire logic run_done,
  output int        pending,
  output int        failures,
  output int        pixel_cnt,
  output int        border_cnt
);
  timeunit 1ns;
  timeprecision 1ps;
  import brs_pkg::*;

  typedef struct packed {
    logic [COL_W-1:0]        col;
    logic [ROW_W-1:0]        row;
    logic signed [VAL_W-1:0] value;
    logic                    edge_copy;
    logic                    saturated;
  } pixel_result_t;

  localparam int              REPORT_LIMIT = 10;
  localparam longint unsigned UNIT         = 64'd1 << FRAC_BITS;

  logic signed [PIX_W-1:0] image [MAX_HEIGHT][MAX_WIDTH];
  logic [DIM_W-1:0]        width_reg, height_reg;
  logic [STEP_W-1:0]       step_x_reg, step_y_reg;
  pixel_result_t           expected_pixels[$];
  bit                      leftover_done;

  function automatic int used_dim(logic [DIM_W-1:0] d, int limit);
    if (d == 0) return 1;
    return (d > limit) ? limit : int'(d);
  endfunction

  function automatic longint pixel_at(int r, int c);
    return longint'(image[r][c]);
  endfunction

  function automatic pixel_result_t resample_pixel(logic [COL_W-1:0] ocol,
                                                   logic [ROW_W-1:0] orow);
    pixel_result_t   r;
    longint unsigned pos_x, pos_y, t, u, scale;
    longint          acc, prod, val;
    int              w, h, j, k;
    w = used_dim(width_reg, MAX_WIDTH);
    h = used_dim(height_reg, MAX_HEIGHT);
    pos_x = ocol * step_x_reg;
    pos_y = orow * step_y_reg;
    j = int'(pos_x >> FRAC_BITS);
    k = int'(pos_y >> FRAC_BITS);
    t = pos_x & (UNIT - 1);
    u = pos_y & (UNIT - 1);
    r.col = ocol;
    r.row = orow;
    r.edge_copy = 1'b0;
    r.saturated = 1'b0;
    if (j + 1 < w && k + 1 < h) begin
      acc = longint'((UNIT - t) * (UNIT - u)) * pixel_at(k, j)
          + longint'(t * (UNIT - u)) * pixel_at(k, j + 1)
          + longint'(t * u) * pixel_at(k + 1, j + 1)
          + longint'((UNIT - t) * u) * pixel_at(k + 1, j);
      acc = acc >>> FRAC_BITS;
      scale = step_x_reg * step_y_reg;
      scale = scale >> FRAC_BITS;
      prod = acc * longint'(scale);
      val = prod >>> FRAC_BITS;
      if (val > VALUE_MAX) begin
        val = VALUE_MAX;
        r.saturated = 1'b1;
      end
      if (val < VALUE_MIN) begin
        val = VALUE_MIN;
        r.saturated = 1'b1;
      end
    end else begin
      // border: copy the nearest pixel, clamped into the image
      val = pixel_at((k < h) ? k : h - 1, (j < w) ? j : w - 1) <<< FRAC_BITS;
      r.edge_copy = 1'b1;
    end
    r.value = val[VAL_W-1:0];
    return r;
  endfunction

  task automatic report(string what, pixel_result_t want, pixel_result_t got);
    failures++;
    if (failures <= REPORT_LIMIT)
      $display({"%s: expected (%0d,%0d) value %0d edge %0b sat %0b,",
                " got (%0d,%0d) value %0d edge %0b sat %0b"},
               what, want.row, want.col, want.value, want.edge_copy, want.saturated,
               got.row, got.col, got.value, got.edge_copy, got.saturated);
  endtask

  always @(posedge clk) begin
    pixel_result_t got, want;
    if (rst) begin
      width_reg  = DIM_W'(MAX_WIDTH);
      height_reg = DIM_W'(MAX_HEIGHT);
      step_x_reg = STEP_W'(UNIT);
      step_y_reg = STEP_W'(UNIT);
      expected_pixels.delete();
    end else begin
      if (res.valid && res.ready) begin
        got = '{res.res_col, res.res_row, res.value, res.edge_copy, res.saturated};
        pixel_cnt++;
        if (got.edge_copy) border_cnt++;
        if (expected_pixels.size() == 0) begin
          report("pixel with no request outstanding", '0, got);
        end else begin
          want = expected_pixels.pop_front();
          if (got !== want) report("pixel mismatch", want, got);
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg_reg_t'(cfg.index))
          REG_SRC_WIDTH:  width_reg  = cfg.data[DIM_W-1:0];
          REG_SRC_HEIGHT: height_reg = cfg.data[DIM_W-1:0];
          REG_STEP_X:     step_x_reg = cfg.data[STEP_W-1:0];
          REG_STEP_Y:     step_y_reg = cfg.data[STEP_W-1:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        if (func_t'(req.func) == FUNC_LOAD)
          image[req.src_row][req.src_col] = req.sample;
        else
          expected_pixels.push_back(resample_pixel(req.out_col, req.out_row));
      end
      if (run_done && !leftover_done) begin
        leftover_done = 1'b1;
        if (expected_pixels.size() != 0) begin
          failures += expected_pixels.size();
          $display("%0d requested pixels never returned", expected_pixels.size());
        end
      end
    end
    pending = expected_pixels.size();
  end

endmodule

FILE: tb/sv/bilinear_image_resampler_core_tb.sv
// Testbench top: clock, reset, load and resample traffic, register settings and verdict.
module bilinear_image_resampler_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import brs_pkg::*;

  localparam int SETTLE_CYCLES = 10;
  localparam int CYCLE_LIMIT   = 600000;

  logic clk;
  logic rst;
  logic run_done;
  int   idle_pct = 0;
  int   stall_pct = 0;
  int   pending, failures, pixel_cnt, border_cnt;
  int   load_cnt, setting_cnt, cycles, item_cnt;
  bit   written [MAX_HEIGHT][MAX_WIDTH];

  logic [DIM_W-1:0]  cur_width  = DIM_W'(MAX_WIDTH);
  logic [DIM_W-1:0]  cur_height = DIM_W'(MAX_HEIGHT);
  logic [STEP_W-1:0] cur_step_x = STEP_W'(1 << FRAC_BITS);
  logic [STEP_W-1:0] cur_step_y = STEP_W'(1 << FRAC_BITS);

  brs_in_if  req();
  brs_out_if res();
  brs_cfg_if cfg();

  bilinear_image_resampler_core dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .res(res),
    .cfg(cfg)
  );

  bilinear_image_resampler_core_checker resample_check (
    .clk(clk),
    .rst(rst),
    .req(req),
    .res(res),
    .cfg(cfg),
    .run_done(run_done),
    .pending(pending),
    .failures(failures),
    .pixel_cnt(pixel_cnt),
    .border_cnt(border_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // output backpressure
  initial begin
    res.ready = 1'b0;
    forever begin
      @(negedge clk);
      res.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d pixels outstanding", cycles, pending);
    $display("bilinear_image_resampler_core_tb: FAIL");
    $finish;
  end

  function automatic int dim_used(logic [DIM_W-1:0] d, int limit);
    if (d == 0) return 1;
    return (d > limit) ? limit : int'(d);
  endfunction

  // dimension in the low bits, junk above them
  function automatic logic [CFG_DATA_W-1:0] dim_word(int d);
    logic [CFG_DATA_W-1:0] word;
    word = CFG_DATA_W'($urandom);
    word[DIM_W-1:0] = DIM_W'(d);
    return word;
  endfunction

  function automatic logic [STEP_W-1:0] rand_step();
    if ($urandom_range(7) == 0) return STEP_W'($urandom_range(20'hFFFFF));
    return STEP_W'($urandom_range(20'h30000, 20'h02000));
  endfunction

  function automatic logic signed [PIX_W-1:0] pick_sample();
    case ($urandom_range(7))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      default: return PIX_W'($urandom);
    endcase
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data  = data;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    case (idx)
      REG_SRC_WIDTH:  cur_width  = data[DIM_W-1:0];
      REG_SRC_HEIGHT: cur_height = data[DIM_W-1:0];
      REG_STEP_X:     cur_step_x = data[STEP_W-1:0];
      REG_STEP_Y:     cur_step_y = data[STEP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [CFG_DATA_W-1:0] w, h, sx, sy);
    write_reg(REG_SRC_WIDTH, w);
    write_reg(REG_SRC_HEIGHT, h);
    write_reg(REG_STEP_X, sx);
    write_reg(REG_STEP_Y, sy);
    cfg.valid = 1'b0;
    setting_cnt++;
  endtask

  task automatic send_item(func_t f, logic [COL_W-1:0] scol, logic [ROW_W-1:0] srow,
                           logic signed [PIX_W-1:0] smp, logic [COL_W-1:0] ocol,
                           logic [ROW_W-1:0] orow);
    while ($urandom_range(99) < idle_pct) begin
      req.valid = 1'b0;
      @(negedge clk);
    end
    req.valid   = 1'b1;
    req.func    = f;
    req.src_col = scol;
    req.src_row = srow;
    req.sample  = smp;
    req.out_col = ocol;
    req.out_row = orow;
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
    item_cnt++;
  endtask

  task automatic load_pixel(int r, int c, logic signed [PIX_W-1:0] v);
    send_item(FUNC_LOAD, COL_W'(c), ROW_W'(r), v, COL_W'($urandom), ROW_W'($urandom));
    written[r][c] = 1'b1;
    load_cnt++;
  endtask

  // load any neighbour the request would read before it was ever written
  task automatic resample(int ocol, int orow);
    longint unsigned pos_x, pos_y;
    int              w, h, j, k;
    w = dim_used(cur_width, MAX_WIDTH);
    h = dim_used(cur_height, MAX_HEIGHT);
    pos_x = ocol * cur_step_x;
    pos_y = orow * cur_step_y;
    j = int'(pos_x >> FRAC_BITS);
    k = int'(pos_y >> FRAC_BITS);
    if (j + 1 < w && k + 1 < h) begin
      for (int dr = 0; dr < 2; dr++)
        for (int dc = 0; dc < 2; dc++)
          if (!written[k + dr][j + dc]) load_pixel(k + dr, j + dc, pick_sample());
    end else begin
      if (j >= w) j = w - 1;
      if (k >= h) k = h - 1;
      if (!written[k][j]) load_pixel(k, j, pick_sample());
    end
    send_item(FUNC_RESAMPLE, COL_W'($urandom), ROW_W'($urandom), PIX_W'($urandom),
              COL_W'(ocol), ROW_W'(orow));
  endtask

  // hold off until every requested pixel is back and the pipe has emptied
  task automatic drain();
    req.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // send about n items, counting the loads a resample pulls in
  task automatic random_traffic(int n);
    int w, h, lim_c, lim_r, first;
    w = dim_used(cur_width, MAX_WIDTH);
    h = dim_used(cur_height, MAX_HEIGHT);
    lim_c = (cur_step_x == 0) ? 255 : int'((w << FRAC_BITS) / cur_step_x) + 1;
    lim_r = (cur_step_y == 0) ? 255 : int'((h << FRAC_BITS) / cur_step_y) + 1;
    if (lim_c > 255) lim_c = 255;
    if (lim_r > 255) lim_r = 255;
    first = item_cnt;
    while (item_cnt - first < n) begin
      case ($urandom_range(9))
        0:       load_pixel($urandom_range(255), $urandom_range(255), pick_sample());
        1:       load_pixel($urandom_range(h - 1), $urandom_range(w - 1), pick_sample());
        2:       resample($urandom_range(255), $urandom_range(255));
        default: resample($urandom_range(lim_c), $urandom_range(lim_r));
      endcase
    end
  endtask

  task automatic run_phase(int idx, int w, int h, logic [STEP_W-1:0] sx, sy, int n);
    configure(dim_word(w), dim_word(h), sx, sy);
    case (idx % 4)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 68; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 68; end
      default: begin idle_pct = 6; stall_pct = 6; end
    endcase
    random_traffic(n);
    drain();
  endtask

  initial begin
    rst         = 1'b1;
    run_done    = 1'b0;
    req.valid   = 1'b0;
    req.func    = FUNC_LOAD;
    req.src_col = '0;
    req.src_row = '0;
    req.sample  = '0;
    req.out_col = '0;
    req.out_row = '0;
    cfg.valid   = 1'b0;
    cfg.index   = REG_SRC_WIDTH;
    cfg.data    = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset settings: corners of the store, loaded with the sample extremes and -1
    load_pixel(0, 0, 16'sh8000);
    load_pixel(0, 1, 16'sh7FFF);
    load_pixel(1, 0, 16'sh7FFF);
    load_pixel(1, 1, 16'sh8000);
    load_pixel(255, 255, 16'sh7FFF);
    load_pixel(0, 255, 16'sh8000);
    load_pixel(255, 0, -16'sd1);
    resample(0, 0);
    resample(255, 255);
    resample(255, 0);
    resample(0, 255);
    drain();

    // zero size acts as one pixel, zero step pins every position to the origin
    configure(dim_word(0), dim_word(0), '0, '0);
    resample(0, 0);
    resample(255, 255);
    drain();

    // oversized dimensions act as the full store; half and three-quarter fractions
    configure(dim_word(511), dim_word(300), 20'h08000, 20'h0C000);
    resample(1, 1);
    resample(3, 1);
    drain();

    // largest steps: maximum scale inside, clamped copy past the image
    configure(dim_word(256), dim_word(256), 20'hFFFFF, 20'hFFFFF);
    resample(0, 0);
    resample(1, 1);
    resample(255, 255);
    drain();

    run_phase(0, 8, 6, 20'h0C000, 20'h14000, 100);
    run_phase(1, 2, 2, 20'h08000, 20'h08000, 100);
    run_phase(2, 1, 5, rand_step(), rand_step(), 100);
    run_phase(3, 16, 12, rand_step(), rand_step(), 110);
    run_phase(4, 256, 256, 20'h10000, 20'h10000, 40);
    run_phase(5, 300, 1, 20'hFFFFF, 20'hFFFFF, 60);
    run_phase(6, 0, 7, 20'h00000, 20'h18000, 80);
    for (int p = 7; p < 12; p++)
      run_phase(p, $urandom_range(24, 1), $urandom_range(24, 1), rand_step(), rand_step(), 100);

    run_done = 1'b1;
    @(negedge clk);
    $display("checked %0d resampled pixels, %0d of them border copies, over %0d items (%0d loads)",
             pixel_cnt, border_cnt, item_cnt, load_cnt);
    $display("%0d register settings from a one-pixel image to the full store, steps 0 to 16",
             setting_cnt);
    if (failures == 0)
      $display("bilinear_image_resampler_core_tb: PASS");
    else
      $display("bilinear_image_resampler_core_tb: FAIL");
    $finish;
  end

endmodule
